[src/lqr_pkg.sv]
// types and constants for the lowest quadratic root in range block
// used by every module of the block; depends on nothing
package lqr_pkg;

  // widths of the datapath
  localparam int DISC_W    = 67;  // signed discriminant, Q32.32
  localparam int SQ_W      = 68;  // square root remainder and partial root
  localparam int SQ_STEPS  = 34;  // one result bit per stage
  localparam int ROOT_W    = 34;  // floor square root, Q16.16
  localparam int NUM_W     = 35;  // signed numerator -b +/- s
  localparam int DEN_W     = 33;  // magnitude of 2a
  localparam int DIV_STEPS = 51;  // numerator magnitude scaled by 2^16
  localparam int FRAC_BITS = 16;

  // input transaction
  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] max_root;
  } lqr_in_t;

  // result transaction
  typedef struct packed {
    logic               found;
    logic signed [31:0] root_value;
  } lqr_out_t;

  // fields carried alongside the square root
  typedef struct packed {
    logic               none;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] max_root;
  } lqr_sb_t;

  // two saturated roots on their way to the range test
  typedef struct packed {
    logic               none;
    logic signed [31:0] max_root;
    logic signed [31:0] root_lo;
    logic signed [31:0] root_hi;
  } lqr_roots_t;

endpackage

[src/lqr_disc.sv]
// discriminant stages: two products, then b*b - 4ac at full width
// depends on lqr_pkg
module lqr_disc (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  lqr_pkg::lqr_in_t                query,
  output logic                            out_valid,
  output logic [lqr_pkg::SQ_W-1:0]        disc,
  output lqr_pkg::lqr_sb_t                sb
);

  logic               p_valid;
  logic signed [63:0] bb;
  logic signed [63:0] ac;
  lqr_pkg::lqr_in_t   p_query;
  logic signed [lqr_pkg::DISC_W-1:0] d_next;

  // stage one: products
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= in_valid;
    end
    bb      <= query.coef_b * query.coef_b;
    ac      <= query.coef_a * query.coef_c;
    p_query <= query;
  end

  // exact discriminant
  assign d_next = {{3{bb[63]}}, bb} - {ac[63], ac, 2'b00};

  // stage two: discriminant and the no-root flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= p_valid;
    end
    disc        <= {1'b0, d_next};
    sb.none     <= d_next[lqr_pkg::DISC_W-1] | (p_query.coef_a == 32'sd0);
    sb.coef_a   <= p_query.coef_a;
    sb.coef_b   <= p_query.coef_b;
    sb.max_root <= p_query.max_root;
  end

endmodule

[src/lqr_isqrt.sv]
// pipelined floor square root, one result bit per stage
// depends on lqr_pkg
module lqr_isqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [lqr_pkg::SQ_W-1:0]         disc,
  input  lqr_pkg::lqr_sb_t                 in_sb,
  output logic                             out_valid,
  output logic [lqr_pkg::ROOT_W-1:0]       root,
  output lqr_pkg::lqr_sb_t                 out_sb
);

  logic                       v   [0:lqr_pkg::SQ_STEPS];
  logic [lqr_pkg::SQ_W-1:0]   rem [0:lqr_pkg::SQ_STEPS];
  logic [lqr_pkg::SQ_W-1:0]   res [0:lqr_pkg::SQ_STEPS];
  lqr_pkg::lqr_sb_t           sb  [0:lqr_pkg::SQ_STEPS];

  assign v[0]   = in_valid;
  assign rem[0] = disc;
  assign res[0] = '0;
  assign sb[0]  = in_sb;

  for (genvar k = 0; k < lqr_pkg::SQ_STEPS; k++) begin : g_step
    localparam int SH = 2 * (lqr_pkg::SQ_STEPS - 1 - k);
    logic [lqr_pkg::SQ_W-1:0] trial;
    logic                     take;

    // try to set the next root bit
    assign trial = res[k] + (lqr_pkg::SQ_W'(1) << SH);
    assign take  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      rem[k+1] <= take ? rem[k] - trial : rem[k];
      res[k+1] <= take ? (res[k] >> 1) + (lqr_pkg::SQ_W'(1) << SH) : res[k] >> 1;
      sb[k+1]  <= sb[k];
    end
  end

  assign out_valid = v[lqr_pkg::SQ_STEPS];
  assign root      = res[lqr_pkg::SQ_STEPS][lqr_pkg::ROOT_W-1:0];
  assign out_sb    = sb[lqr_pkg::SQ_STEPS];

endmodule

[src/lqr_div.sv]
// both roots: numerators, two pipelined restoring dividers, saturation
// depends on lqr_pkg
module lqr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [lqr_pkg::ROOT_W-1:0]    root,
  input  lqr_pkg::lqr_sb_t              in_sb,
  output logic                          out_valid,
  output lqr_pkg::lqr_roots_t           roots
);

  localparam int ND = lqr_pkg::DIV_STEPS;

  logic signed [lqr_pkg::NUM_W-1:0] nb;
  logic signed [lqr_pkg::NUM_W-1:0] num [0:1];
  logic signed [lqr_pkg::DEN_W-1:0] den;
  logic [lqr_pkg::NUM_W-1:0]        num_mag [0:1];

  logic                     v    [0:ND];
  logic                     none [0:ND];
  logic signed [31:0]       lim  [0:ND];
  logic [lqr_pkg::DEN_W-1:0] dv  [0:ND];
  logic                     neg  [0:1][0:ND];
  logic [ND-1:0]            n    [0:1][0:ND];
  logic [lqr_pkg::DEN_W-1:0] rem [0:1][0:ND];
  logic signed [31:0]       q_sat [0:1];

  // numerators and denominator
  assign nb     = -{{3{in_sb.coef_b[31]}}, in_sb.coef_b};
  assign num[0] = nb - $signed({1'b0, root});
  assign num[1] = nb + $signed({1'b0, root});
  assign den    = {in_sb.coef_a, 1'b0};
  assign num_mag[0] = num[0][lqr_pkg::NUM_W-1] ? -num[0] : num[0];
  assign num_mag[1] = num[1][lqr_pkg::NUM_W-1] ? -num[1] : num[1];

  // prep stage: magnitudes and quotient signs
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
    none[0] <= in_sb.none;
    lim[0]  <= in_sb.max_root;
    dv[0]   <= den[lqr_pkg::DEN_W-1] ? -den : den;
    for (int j = 0; j < 2; j++) begin
      n[j][0]   <= {num_mag[j], {lqr_pkg::FRAC_BITS{1'b0}}};
      rem[j][0] <= '0;
      neg[j][0] <= num[j][lqr_pkg::NUM_W-1] ^ den[lqr_pkg::DEN_W-1];
    end
  end

  // division stages, one quotient bit each
  for (genvar k = 0; k < ND; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      none[k+1] <= none[k];
      lim[k+1]  <= lim[k];
      dv[k+1]   <= dv[k];
    end

    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic [lqr_pkg::DEN_W:0] t;
      logic                    ge;
      assign t  = {rem[j][k], n[j][k][ND-1]};
      assign ge = t >= {1'b0, dv[k]};
      always_ff @(posedge clk) begin
        rem[j][k+1] <= ge ? lqr_pkg::DEN_W'(t - {1'b0, dv[k]}) : t[lqr_pkg::DEN_W-1:0];
        n[j][k+1]   <= {n[j][k][ND-2:0], ge};
        neg[j][k+1] <= neg[j][k];
      end
    end
  end

  // signed quotient saturated to Q16.16
  for (genvar j = 0; j < 2; j++) begin : g_sat
    logic signed [ND+1:0] q;
    assign q = neg[j][ND] ? -$signed({2'b00, n[j][ND]}) : $signed({2'b00, n[j][ND]});
    always_comb begin
      priority if (q > (ND+2)'(64'sd2147483647)) begin
        q_sat[j] = 32'sh7fffffff;
      end else if (q < -(ND+2)'(64'sd2147483648)) begin
        q_sat[j] = 32'sh80000000;
      end else begin
        q_sat[j] = q[31:0];
      end
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v[ND];
    end
    roots.none     <= none[ND];
    roots.max_root <= lim[ND];
    roots.root_lo  <= q_sat[0];
    roots.root_hi  <= q_sat[1];
  end

endmodule

[src/lqr_select.sv]
// orders the two roots and picks the lowest one inside (0, max_root)
// depends on lqr_pkg
module lqr_select (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  lqr_pkg::lqr_roots_t  roots,
  output logic                 done,
  output lqr_pkg::lqr_out_t    result
);

  logic signed [31:0] r_min;
  logic signed [31:0] r_max;
  logic               min_ok;
  logic               max_ok;

  // sort and range test
  assign r_min  = (roots.root_lo > roots.root_hi) ? roots.root_hi : roots.root_lo;
  assign r_max  = (roots.root_lo > roots.root_hi) ? roots.root_lo : roots.root_hi;
  assign min_ok = (r_min > 32'sd0) && (r_min < roots.max_root);
  assign max_ok = (r_max > 32'sd0) && (r_max < roots.max_root);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    result.found <= !roots.none && (min_ok || max_ok);
    priority if (roots.none) begin
      result.root_value <= 32'sd0;
    end else if (min_ok) begin
      result.root_value <= r_min;
    end else if (max_ok) begin
      result.root_value <= r_max;
    end else begin
      result.root_value <= 32'sd0;
    end
  end

endmodule

[src/lowest_quadratic_root_in_range.sv]
// top level of the lowest quadratic root in range block
// depends on lqr_pkg, lqr_disc, lqr_isqrt, lqr_div, lqr_select
//
// usage:
//   a transaction enters when start is high and busy is low; query holds
//   coef_a, coef_b, coef_c and max_root, all signed Q16.16
//   busy is always low: a new transaction may enter in every cycle
//   each transaction gives one result on result, marked by done for one
//   cycle, in entry order
//   result.found is set when coef_a is nonzero and a root lies strictly in
//   (0, max_root), and result.root_value then holds the lowest such root, otherwise zero
// pipeline and throughput:
//   discriminant stages, then the square root (one bit a stage), then the
//   two dividers (prep, 51 quotient bits, saturation) and the range test;
//   one transaction per cycle sustained
// reset:
//   rst clears every stage valid; transactions in flight are dropped
// the receiver cannot stall: results are shown once and not held
module lowest_quadratic_root_in_range (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lqr_pkg::lqr_in_t   query,
  output logic               done,
  output lqr_pkg::lqr_out_t  result
);

  logic                          d_valid;
  logic [lqr_pkg::SQ_W-1:0]      disc;
  lqr_pkg::lqr_sb_t              d_sb;
  logic                          s_valid;
  logic [lqr_pkg::ROOT_W-1:0]    root;
  lqr_pkg::lqr_sb_t              s_sb;
  logic                          r_valid;
  lqr_pkg::lqr_roots_t           roots;

  assign busy = 1'b0;

  lqr_disc u_disc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .query     (query),
    .out_valid (d_valid),
    .disc      (disc),
    .sb        (d_sb)
  );

  lqr_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .disc      (disc),
    .in_sb     (d_sb),
    .out_valid (s_valid),
    .root      (root),
    .out_sb    (s_sb)
  );

  lqr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .root      (root),
    .in_sb     (s_sb),
    .out_valid (r_valid),
    .roots     (roots)
  );

  lqr_select u_select (
    .clk      (clk),
    .rst      (rst),
    .in_valid (r_valid),
    .roots    (roots),
    .done     (done),
    .result   (result)
  );

  // a missing root always reads as zero
  a_zero_when_none: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.root_value == 32'sd0)
    else $error("root_value not zero without a root");

  // a reported root is strictly positive
  a_found_positive: assert property (@(posedge clk) disable iff (rst)
    done && result.found |-> result.root_value > 32'sd0)
    else $error("reported root not positive");

  // a result only leaves a valid stage
  a_done_from_pipe: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(r_valid))
    else $error("done without a transaction in the last stage");

endmodule
